### design/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// shared types and constants of the terminal cursor controller
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;

  // column count / cursor column (0..MAX_COLUMNS), cell column, row, row count
  localparam int COL_W   = $clog2(MAX_COLUMNS + 1);
  localparam int CCOL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int NROWS_W = $clog2(MAX_ROWS + 1);
  localparam int CFG_W   = 64;
  localparam int REG_W   = 3;

  localparam logic [COL_W-1:0]   MAX_COLS_V   = COL_W'(MAX_COLUMNS);
  localparam logic [NROWS_W-1:0] MAX_ROWS_V   = NROWS_W'(MAX_ROWS);
  localparam logic [7:0]         CODE_OFFSET  = 8'd32;
  localparam logic [63:0]        TAB_DEFAULT  = 64'h0101_0101_0101_0101;
  localparam logic [7:0]         COLS_RESET   = 8'd80;
  localparam logic [6:0]         ROWS_RESET   = 7'd24;
  localparam logic [6:0]         LOCK_RESET   = 7'h7f;

  typedef enum logic [3:0] {
    CMD_PRINT   = 4'd0,
    CMD_BS      = 4'd1,
    CMD_TAB     = 4'd2,
    CMD_LF      = 4'd3,
    CMD_CR      = 4'd4,
    CMD_UP      = 4'd5,
    CMD_DOWN    = 4'd6,
    CMD_RIGHT   = 4'd7,
    CMD_LEFT    = 4'd8,
    CMD_HOME    = 4'd9,
    CMD_RI      = 4'd10,
    CMD_ADDRESS = 4'd11
  } cmd_t;

  typedef enum logic [REG_W-1:0] {
    REG_COLUMNS   = 3'd0,
    REG_ROWS      = 3'd1,
    REG_WRAP      = 3'd2,
    REG_REV_WRAP  = 3'd3,
    REG_INSERT    = 3'd4,
    REG_LOCK_END  = 3'd5,
    REG_TAB_LOW   = 3'd6,
    REG_TAB_HIGH  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [3:0] command;
    logic [7:0] char_code;
    logic [7:0] row_code;
    logic [7:0] col_code;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] cursor_col;
    logic [5:0] cursor_row;
    logic       scroll_up;
    logic       scroll_down;
    logic       cell_write;
    logic       cell_insert;
    logic [5:0] cell_row;
    logic [6:0] cell_col;
    logic [7:0] cell_char;
  } res_item_t;

  typedef struct packed {
    logic [7:0]             columns;
    logic [6:0]             rows;
    logic                   wrap_enable;
    logic                   reverse_wrap;
    logic                   insert_mode;
    logic [6:0]             locked_rows_end;
    logic [MAX_COLUMNS-1:0] tab_stops;
  } cfg_t;

endpackage

### design/tcc_tab_find.sv
// ----------------------------------------------------------------------------
// tcc_tab_find
// priority encoder for the next tab stop right of the cursor
// ----------------------------------------------------------------------------
module tcc_tab_find
  import tcc_pkg::*;
(
  input  logic [MAX_COLUMNS-1:0] stops,
  input  logic [COL_W-1:0]       x,
  input  logic [COL_W-1:0]       cols,
  output logic                   found,
  output logic [CCOL_W-1:0]      pos
);

  logic [MAX_COLUMNS-1:0] hit;

  // only stops strictly right of the cursor and inside the screen count
  always_comb begin
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      hit[i] = stops[i] && (COL_W'(i) > x) && (COL_W'(i) < cols);
    end
  end

  always_comb begin
    found = |hit;
    pos   = '0;
    for (int i = MAX_COLUMNS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        pos = CCOL_W'(i);
      end
    end
  end

endmodule

### design/tcc_step.sv
// ----------------------------------------------------------------------------
// tcc_step
// next cursor position, scroll requests and cell write for one command
// ----------------------------------------------------------------------------
module tcc_step
  import tcc_pkg::*;
(
  input  cfg_t              cfg,
  input  logic [COL_W-1:0]  col_position,
  input  logic [ROW_W-1:0]  row_position,
  input  cmd_item_t         item,
  output logic [COL_W-1:0]  col_next,
  output logic [ROW_W-1:0]  row_next,
  output res_item_t         res
);

  logic [COL_W-1:0]   cols;
  logic [COL_W-1:0]   cols_m1;
  logic [NROWS_W-1:0] nrows;
  logic [ROW_W-1:0]   rows_m1;
  logic [COL_W-1:0]   x0;
  logic [ROW_W-1:0]   y0;
  logic [COL_W:0]     x_inc;
  logic [ROW_W:0]     y_inc;
  logic signed [6:0]  lock;
  logic               tab_found;
  logic [CCOL_W-1:0]  tab_pos;
  logic [7:0]         rc;
  logic [7:0]         cc;
  logic [COL_W-1:0]   px;
  logic [ROW_W-1:0]   py;
  logic [COL_W-1:0]   x;
  logic [ROW_W-1:0]   y;

  // out-of-range register values are clamped
  always_comb begin
    if (cfg.columns == '0) begin
      cols = COL_W'(1);
    end else if (cfg.columns > MAX_COLS_V) begin
      cols = MAX_COLS_V;
    end else begin
      cols = cfg.columns;
    end
    if (cfg.rows == '0) begin
      nrows = NROWS_W'(1);
    end else if (cfg.rows > MAX_ROWS_V) begin
      nrows = MAX_ROWS_V;
    end else begin
      nrows = cfg.rows;
    end
  end

  assign cols_m1 = cols - COL_W'(1);
  assign rows_m1 = ROW_W'(nrows - NROWS_W'(1));
  assign lock    = $signed(cfg.locked_rows_end);

  // a shrunk screen pulls the stored cursor back in
  assign x0    = (col_position > cols) ? cols : col_position;
  assign y0    = ({1'b0, row_position} > {1'b0, rows_m1}) ? rows_m1 : row_position;
  assign x_inc = {1'b0, x0} + (COL_W + 1)'(1);
  assign y_inc = {1'b0, y0} + (ROW_W + 1)'(1);

  assign rc = (item.row_code > CODE_OFFSET) ? item.row_code - CODE_OFFSET : 8'd0;
  assign cc = (item.col_code > CODE_OFFSET) ? item.col_code - CODE_OFFSET : 8'd0;

  tcc_tab_find u_tab (
    .stops (cfg.tab_stops),
    .x     (x0),
    .cols  (cols),
    .found (tab_found),
    .pos   (tab_pos)
  );

  always_comb begin
    x   = x0;
    y   = y0;
    px  = x0;
    py  = y0;
    res = '0;
    unique case (cmd_t'(item.command))
      CMD_PRINT: begin
        if (!cfg.insert_mode) begin
          // deferred wrap
          if (x0 >= cols) begin
            if (cfg.wrap_enable) begin
              px = '0;
              if (y_inc >= (ROW_W + 1)'(nrows)) begin
                py            = rows_m1;
                res.scroll_up = 1'b1;
              end else begin
                py = y_inc[ROW_W-1:0];
              end
            end else begin
              px = cols_m1;
            end
          end
          if ($signed({1'b0, py}) > lock) begin
            res.cell_write = 1'b1;
            res.cell_row   = py;
            res.cell_col   = px[CCOL_W-1:0];
            res.cell_char  = item.char_code;
          end
          x = px + COL_W'(1);
          y = py;
        end else if (x0 < cols) begin
          if ($signed({1'b0, y0}) > lock) begin
            res.cell_write  = 1'b1;
            res.cell_insert = 1'b1;
            res.cell_row    = y0;
            res.cell_col    = x0[CCOL_W-1:0];
            res.cell_char   = item.char_code;
          end
          x = x_inc[COL_W-1:0];
        end
      end
      CMD_BS: begin
        if (x0 != '0) begin
          px = (x0 >= cols) ? cols_m1 : x0;
          x  = (px != '0) ? px - COL_W'(1) : px;
        end else if (cfg.reverse_wrap && (y0 != '0)) begin
          y = y0 - ROW_W'(1);
          x = cols_m1;
        end
      end
      CMD_TAB: begin
        x = tab_found ? COL_W'(tab_pos) : cols_m1;
      end
      CMD_LF: begin
        if (y_inc >= (ROW_W + 1)'(nrows)) begin
          y             = rows_m1;
          res.scroll_up = 1'b1;
        end else begin
          y = y_inc[ROW_W-1:0];
        end
      end
      CMD_CR: begin
        x = '0;
      end
      CMD_UP: begin
        if (y0 != '0) begin
          y = y0 - ROW_W'(1);
        end
      end
      CMD_DOWN: begin
        if (y_inc < (ROW_W + 1)'(nrows)) begin
          y = y_inc[ROW_W-1:0];
        end
      end
      CMD_RIGHT: begin
        x = (x_inc >= {1'b0, cols}) ? cols_m1 : x_inc[COL_W-1:0];
      end
      CMD_LEFT: begin
        if (x0 != '0) begin
          x = x0 - COL_W'(1);
        end
      end
      CMD_HOME: begin
        x = '0;
        y = '0;
      end
      CMD_RI: begin
        if (y0 == '0) begin
          res.scroll_down = 1'b1;
        end else begin
          y = y0 - ROW_W'(1);
        end
      end
      CMD_ADDRESS: begin
        x = (cc >= 8'(cols)) ? cols_m1 : COL_W'(cc);
        y = (rc >= 8'(nrows)) ? rows_m1 : rc[ROW_W-1:0];
      end
      default: begin
        // unused codes leave the cursor where it is
      end
    endcase
    res.cursor_col = x;
    res.cursor_row = y;
  end

  assign col_next = x;
  assign row_next = y;

endmodule

### design/tcc_out_buf.sv
// ----------------------------------------------------------------------------
// tcc_out_buf
// result register with a skid entry
// ----------------------------------------------------------------------------
module tcc_out_buf
  import tcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  res_item_t push_item,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res_item
);

  logic      skid_valid;
  res_item_t skid_item;
  logic      push;
  logic      pop;

  assign push_ready = !skid_valid;
  assign push       = push_valid && push_ready;
  assign pop        = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        res_item   <= skid_item;
        skid_valid <= 1'b0;
      end
    end else if (!res_valid || pop) begin
      res_valid <= push;
      if (push) begin
        res_item <= push_item;
      end
    end else if (push) begin
      skid_item  <= push_item;
      skid_valid <= 1'b1;
    end
  end

endmodule

### design/terminal_cursor_controller.sv
// ----------------------------------------------------------------------------
// terminal_cursor_controller
// cursor tracking for a vt52-style text terminal, one command per item
// ----------------------------------------------------------------------------
// usage
//   cmd channel: one command item (print, backspace, tab, line feed, carriage
//   return, up, down, right, left, home, reverse index, direct address)
//   res channel: one result item per command with the new cursor position,
//   scroll requests and the cell write for the screen memory
//   cfg channel: register index and data; always ready, write only while the
//   block is idle
// timing
//   the cursor update is one combinational pass from the accepted item and
//   the position registers into the result register, so a command is taken
//   every cycle while the skid entry is empty; a stalled result waits in it
//   the tab search is a 128-bit priority encoder in the same pass
// reset
//   rst is synchronous; the cursor goes to row 0 column 0, registers take
//   their default values and both result entries are emptied
// stalls
//   a skid entry holds one more result while res is stalled; cmd_ready drops
//   only when both entries are full
// ----------------------------------------------------------------------------
module terminal_cursor_controller
  import tcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_item_t        cmd_item,
  output logic             res_valid,
  input  logic             res_ready,
  output res_item_t        res_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [REG_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t             cfg;
  logic [COL_W-1:0] col_position;
  logic [ROW_W-1:0] row_position;
  logic [COL_W-1:0] col_position_next;
  logic [ROW_W-1:0] row_position_next;
  res_item_t        step_res;
  logic             cmd_accept;

  assign cfg_ready  = 1'b1;
  assign cmd_accept = cmd_valid && cmd_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns         <= COLS_RESET;
      cfg.rows            <= ROWS_RESET;
      cfg.wrap_enable     <= 1'b1;
      cfg.reverse_wrap    <= 1'b0;
      cfg.insert_mode     <= 1'b0;
      cfg.locked_rows_end <= LOCK_RESET;
      cfg.tab_stops       <= {TAB_DEFAULT, TAB_DEFAULT};
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_COLUMNS:  cfg.columns         <= cfg_data[7:0];
        REG_ROWS:     cfg.rows            <= cfg_data[6:0];
        REG_WRAP:     cfg.wrap_enable     <= cfg_data[0];
        REG_REV_WRAP: cfg.reverse_wrap    <= cfg_data[0];
        REG_INSERT:   cfg.insert_mode     <= cfg_data[0];
        REG_LOCK_END: cfg.locked_rows_end <= cfg_data[6:0];
        REG_TAB_LOW:  cfg.tab_stops[63:0] <= cfg_data;
        REG_TAB_HIGH: cfg.tab_stops[MAX_COLUMNS-1:64] <= cfg_data[MAX_COLUMNS-65:0];
        default: begin
        end
      endcase
    end
  end

  // cursor state moves on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      col_position <= '0;
      row_position <= '0;
    end else if (cmd_accept) begin
      col_position <= col_position_next;
      row_position <= row_position_next;
    end
  end

  tcc_step u_step (
    .cfg          (cfg),
    .col_position (col_position),
    .row_position (row_position),
    .item         (cmd_item),
    .col_next     (col_position_next),
    .row_next     (row_position_next),
    .res          (step_res)
  );

  tcc_out_buf u_out (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_item  (step_res),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
  );

  // the cursor column never passes the widest screen's pending-wrap position
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col_position <= MAX_COLS_V)
    else $error("cursor column out of range");

  // home always lands at the origin
  a_home: assert property (@(posedge clk) disable iff (rst)
    cmd_accept && (cmd_item.command == CMD_HOME) |=>
      (col_position == '0) && (row_position == '0))
    else $error("home did not reach origin");

  // back-pressure only when a result is waiting
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> res_valid)
    else $error("input stalled with no pending result");

  // a result without a write carries an empty cell
  a_cell_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.cell_write |->
      !res_item.cell_insert && (res_item.cell_row == '0) &&
      (res_item.cell_col == '0) && (res_item.cell_char == '0))
    else $error("cell fields set without a write");

endmodule

### tb/sv/tb_terminal_cursor_controller.sv
// ----------------------------------------------------------------------------
// tb_terminal_cursor_controller
// self-checking bench for the terminal cursor controller
// ----------------------------------------------------------------------------
// A directed run covers the screen edges, every command and the corner modes.
// Random traffic follows under several register settings, among them the
// smallest, largest and out-of-range screens. A cycle-level mirror of the
// cursor predicts each result when its command is accepted. A monitor compares
// every result item field by field against the oldest prediction. Both sides
// idle at random, in three phases with different idle rates.
// ----------------------------------------------------------------------------
module tb_terminal_cursor_controller;
  import tcc_pkg::*;

  localparam int STALL_LIMIT   = 5000;  // cycles with no item moving on any channel
  localparam int PRINT_CAP     = 100;   // mismatch lines shown, the rest only counted
  localparam int ITEMS_PER_SET = 60;    // random items per register setting

  // command codes the block treats as no operation
  localparam logic [3:0] CMD_SPARE_LO = 4'd12;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_ready;
  cmd_item_t        cmd_item  = '0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  res_item_t        res_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [REG_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;

  // idle rates in percent of cycles, changed per traffic phase
  int send_idle_pct = 20;
  int recv_idle_pct = 79;

  int mismatch_count = 0;
  int quiet_cycles   = 0;

  // mirror of the register file, updated when a write is accepted
  logic [7:0]             mirror_columns;
  logic [6:0]             mirror_rows;
  logic                   mirror_wrap;
  logic                   mirror_rev_wrap;
  logic                   mirror_insert;
  logic [6:0]             mirror_lock_end;
  logic [MAX_COLUMNS-1:0] mirror_tabs;

  // mirror of the cursor position
  logic [7:0] track_col;
  logic [5:0] track_row;

  // predicted result items, oldest first
  res_item_t pending_cursor_results[$];
  res_item_t expected_now;

  terminal_cursor_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  // column count in use; zero counts as one, large values saturate
  function automatic int eff_columns(logic [7:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_COLUMNS) return MAX_COLUMNS;
    return int'(raw);
  endfunction

  function automatic int eff_rows(logic [6:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_ROWS) return MAX_ROWS;
    return int'(raw);
  endfunction

  // register value with random junk above the field, which the block drops
  function automatic logic [63:0] with_noise(logic [63:0] value, int width);
    logic [63:0] keep;
    keep = (64'd1 << width) - 64'd1;
    return ({$urandom, $urandom} & ~keep) | (value & keep);
  endfunction

  function automatic cmd_item_t make_item(logic [3:0] cmd, logic [7:0] ch,
                                          logic [7:0] rc, logic [7:0] cc);
    cmd_item_t item;
    item.command   = cmd;
    item.char_code = ch;
    item.row_code  = rc;
    item.col_code  = cc;
    return item;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // cursor predictor: applies one command to the mirrored position and queues
  // the result item the block has to produce for it
  // ---------------------------------------------------------------------------
  task automatic advance_cursor(input cmd_item_t item);
    int        cols;
    int        nrows;
    int        lock;
    int        x;
    int        y;
    int        c;
    res_item_t r;
    cols  = eff_columns(mirror_columns);
    nrows = eff_rows(mirror_rows);
    lock  = int'($signed(mirror_lock_end));
    r     = '0;
    x     = int'(track_col);
    y     = int'(track_row);
    // a shrunk screen pulls the stored cursor back inside
    if (x > cols) x = cols;
    if (y > nrows - 1) y = nrows - 1;

    case (item.command)
      CMD_PRINT: begin
        if (!mirror_insert) begin
          // wrap pending: next line when wrap is on, else overwrite last column
          if (x >= cols) begin
            if (mirror_wrap) begin
              x = 0;
              y++;
              if (y >= nrows) begin
                y = nrows - 1;
                r.scroll_up = 1'b1;
              end
            end else begin
              x = cols - 1;
            end
          end
          // rows up to the lock boundary are protected, cursor moves anyway
          if (y > lock) begin
            r.cell_write = 1'b1;
            r.cell_row   = 6'(y);
            r.cell_col   = 7'(x);
            r.cell_char  = item.char_code;
          end
          x++;
        end else if (x < cols) begin
          // insert never wraps; at the count the character is dropped
          if (y > lock) begin
            r.cell_write  = 1'b1;
            r.cell_insert = 1'b1;
            r.cell_row    = 6'(y);
            r.cell_col    = 7'(x);
            r.cell_char   = item.char_code;
          end
          x++;
        end
      end
      CMD_BS: begin
        if (x > 0) begin
          if (x >= cols) x = cols - 1;
          if (x > 0) x--;
        end else if (mirror_rev_wrap && y > 0) begin
          y--;
          x = cols - 1;
        end
      end
      CMD_TAB: begin
        // next stop inside the screen, else the last column
        c = x + 1;
        while (c < cols && !mirror_tabs[c]) c++;
        x = (c < cols) ? c : cols - 1;
      end
      CMD_LF: begin
        y++;
        if (y >= nrows) begin
          y = nrows - 1;
          r.scroll_up = 1'b1;
        end
      end
      CMD_CR:    x = 0;
      CMD_UP:    if (y > 0) y--;
      CMD_DOWN:  if (y + 1 < nrows) y++;
      CMD_RIGHT: begin
        x++;
        if (x >= cols) x = cols - 1;
      end
      CMD_LEFT:  if (x > 0) x--;
      CMD_HOME: begin
        x = 0;
        y = 0;
      end
      CMD_RI: begin
        if (y == 0) r.scroll_down = 1'b1;
        else y--;
      end
      CMD_ADDRESS: begin
        y = (item.row_code > CODE_OFFSET) ? int'(item.row_code) - int'(CODE_OFFSET) : 0;
        x = (item.col_code > CODE_OFFSET) ? int'(item.col_code) - int'(CODE_OFFSET) : 0;
        if (x >= cols) x = cols - 1;
        if (y >= nrows) y = nrows - 1;
      end
      default: ;  // spare codes only report the position
    endcase

    track_col    = 8'(x);
    track_row    = 6'(y);
    r.cursor_col = track_col;
    r.cursor_row = track_row;
    pending_cursor_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // monitor: samples at the clock edge, before the bench or the block update
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      mirror_columns  = COLS_RESET;
      mirror_rows     = ROWS_RESET;
      mirror_wrap     = 1'b1;
      mirror_rev_wrap = 1'b0;
      mirror_insert   = 1'b0;
      mirror_lock_end = LOCK_RESET;
      mirror_tabs     = {TAB_DEFAULT, TAB_DEFAULT};
      track_col       = '0;
      track_row       = '0;
      pending_cursor_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COLUMNS:  mirror_columns    = cfg_data[7:0];
          REG_ROWS:     mirror_rows       = cfg_data[6:0];
          REG_WRAP:     mirror_wrap       = cfg_data[0];
          REG_REV_WRAP: mirror_rev_wrap   = cfg_data[0];
          REG_INSERT:   mirror_insert     = cfg_data[0];
          REG_LOCK_END: mirror_lock_end   = cfg_data[6:0];
          REG_TAB_LOW:  mirror_tabs[63:0]   = cfg_data;
          REG_TAB_HIGH: mirror_tabs[127:64] = cfg_data;
          default: ;
        endcase
      end
      if (cmd_valid && cmd_ready) advance_cursor(cmd_item);
      if (res_valid && res_ready) begin
        if (pending_cursor_results.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          expected_now = pending_cursor_results.pop_front();
          check_field("cursor_col",  res_item.cursor_col,  expected_now.cursor_col);
          check_field("cursor_row",  res_item.cursor_row,  expected_now.cursor_row);
          check_field("scroll_up",   res_item.scroll_up,   expected_now.scroll_up);
          check_field("scroll_down", res_item.scroll_down, expected_now.scroll_down);
          check_field("cell_write",  res_item.cell_write,  expected_now.cell_write);
          check_field("cell_insert", res_item.cell_insert, expected_now.cell_insert);
          check_field("cell_row",    res_item.cell_row,    expected_now.cell_row);
          check_field("cell_col",    res_item.cell_col,    expected_now.cell_col);
          check_field("cell_char",   res_item.cell_char,   expected_now.cell_char);
        end
      end
    end
  end

  // receiver stalls, one draw per cycle
  always @(posedge clk) res_ready <= ($urandom_range(99) >= recv_idle_pct);

  // watchdog: a hang shows up as a long run of cycles where nothing moves
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // valid stays high across back-to-back items and drops only for a gap
  task automatic send_command(input cmd_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item  <= item;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  task automatic place_cursor(input int row, input int col);
    send_command(make_item(CMD_ADDRESS, 8'($urandom), 8'(int'(CODE_OFFSET) + row),
                           8'(int'(CODE_OFFSET) + col)));
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and let every predicted result come back
  task automatic wait_cursor_idle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_cursor_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset screen 80 x 24: clamped addressing, deferred wrap, scrolling at both
  // ends, every motion command, up and left at their limit, spare codes
  task automatic test_default_screen();
    send_command(make_item(CMD_ADDRESS, 8'hff, 8'h00, 8'h00));  // codes below offset
    send_command(make_item(CMD_PRINT, 8'h00, 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_ADDRESS, 8'h00, 8'hff, 8'hff));  // clamp to bottom right
    send_command(make_item(CMD_PRINT, 8'hff, 8'($urandom), 8'($urandom)));  // wrap pending
    send_command(make_item(CMD_PRINT, 8'h41, 8'($urandom), 8'($urandom)));  // wrap + scroll
    send_command(make_item(CMD_LF, 8'($urandom), 8'h00, 8'hff));  // scroll at bottom
    send_command(make_item(CMD_TAB, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_HOME, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_RI, 8'($urandom), 8'($urandom), 8'($urandom)));  // scroll down
    send_command(make_item(CMD_DOWN, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_RI, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_UP, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_LEFT, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_RIGHT, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_BS, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_CR, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_SPARE_LO, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_SPARE_HI, 8'($urandom), 8'($urandom), 8'($urandom)));
    place_cursor(23, 79);  // leave the cursor where a smaller screen must clamp it
  endtask

  // 8 x 2 screen, no wrap, reverse wrap, row 0 locked, no tab stops; then insert
  task automatic test_edge_modes();
    wait_cursor_idle();
    write_register(REG_COLUMNS, 64'd8);
    write_register(REG_ROWS, 64'd2);
    write_register(REG_WRAP, 64'd0);
    write_register(REG_REV_WRAP, 64'd1);
    write_register(REG_INSERT, 64'd0);
    write_register(REG_LOCK_END, 64'd0);
    write_register(REG_TAB_LOW, 64'd0);
    write_register(REG_TAB_HIGH, 64'd0);
    send_command(make_item(CMD_RIGHT, 8'($urandom), 8'($urandom), 8'($urandom)));  // clamp
    place_cursor(1, 7);
    send_command(make_item(CMD_PRINT, 8'h78, 8'($urandom), 8'($urandom)));
    // wrap pending with wrap off: overwrite the last column again
    send_command(make_item(CMD_PRINT, 8'h79, 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_BS, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_TAB, 8'($urandom), 8'($urandom), 8'($urandom)));  // no stop
    send_command(make_item(CMD_HOME, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_PRINT, 8'h7a, 8'($urandom), 8'($urandom)));  // locked row
    send_command(make_item(CMD_BS, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_BS, 8'($urandom), 8'($urandom), 8'($urandom)));  // top left
    send_command(make_item(CMD_DOWN, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_BS, 8'($urandom), 8'($urandom), 8'($urandom)));  // back a line
    wait_cursor_idle();
    write_register(REG_INSERT, 64'd1);
    write_register(REG_LOCK_END, 64'(LOCK_RESET));
    place_cursor(1, 6);
    send_command(make_item(CMD_PRINT, 8'h31, 8'($urandom), 8'($urandom)));
    send_command(make_item(CMD_PRINT, 8'h32, 8'($urandom), 8'($urandom)));
    // insert with wrap pending: no write, column stays at the count
    send_command(make_item(CMD_PRINT, 8'h33, 8'($urandom), 8'($urandom)));
  endtask

  // random commands under six register settings: smallest screen, largest
  // screen, out-of-range sizes, then three random ones biased to small screens
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
    int          k;
    int          pick;
    int          cols;
    int          nrows;
    logic [7:0]  cols_v;
    logic [6:0]  rows_v;
    logic        wrap_v;
    logic        rev_v;
    logic        ins_v;
    logic [6:0]  lock_v;
    logic [63:0] tab_lo;
    logic [63:0] tab_hi;
    cmd_item_t   item;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (k = 0; k < 6; k++) begin
      wait_cursor_idle();
      wrap_v = 1'($urandom);
      rev_v  = 1'($urandom);
      ins_v  = 1'($urandom);
      tab_lo = {$urandom, $urandom};
      tab_hi = {$urandom, $urandom};
      case (k)
        0: begin
          cols_v = 8'd1;
          rows_v = 7'd1;
          lock_v = LOCK_RESET;
          tab_lo = '0;
          tab_hi = '0;
        end
        1: begin
          cols_v = 8'(MAX_COLUMNS);
          rows_v = 7'(MAX_ROWS);
          lock_v = 7'(MAX_ROWS - 1);
          tab_lo = '1;
          tab_hi = '1;
        end
        2: begin
          cols_v = $urandom_range(1) ? 8'd0 : 8'hff;
          rows_v = $urandom_range(1) ? 7'd0 : 7'h7f;
          lock_v = 7'($urandom);
        end
        default: begin
          cols_v = $urandom_range(1) ? 8'($urandom_range(12, 1))
                                     : 8'($urandom_range(MAX_COLUMNS, 1));
          rows_v = $urandom_range(1) ? 7'($urandom_range(6, 1))
                                     : 7'($urandom_range(MAX_ROWS, 1));
          case ($urandom_range(3))
            0, 1:    lock_v = LOCK_RESET;
            2:       lock_v = 7'($urandom_range(eff_rows(rows_v)));
            default: lock_v = 7'($urandom);
          endcase
          case ($urandom_range(2))
            0: begin
              tab_lo = tab_lo & {$urandom, $urandom} & {$urandom, $urandom};
              tab_hi = tab_hi & {$urandom, $urandom} & {$urandom, $urandom};
            end
            1: begin
              tab_lo = TAB_DEFAULT;
              tab_hi = TAB_DEFAULT;
            end
            default: ;
          endcase
        end
      endcase
      write_register(REG_COLUMNS,  with_noise(64'(cols_v), 8));
      write_register(REG_ROWS,     with_noise(64'(rows_v), 7));
      write_register(REG_WRAP,     with_noise(64'(wrap_v), 1));
      write_register(REG_REV_WRAP, with_noise(64'(rev_v), 1));
      write_register(REG_INSERT,   with_noise(64'(ins_v), 1));
      write_register(REG_LOCK_END, with_noise(64'(lock_v), 7));
      write_register(REG_TAB_LOW,  tab_lo);
      write_register(REG_TAB_HIGH, tab_hi);

      cols  = eff_columns(cols_v);
      nrows = eff_rows(rows_v);
      repeat (ITEMS_PER_SET) begin
        item.char_code = 8'($urandom);
        item.row_code  = 8'($urandom);
        item.col_code  = 8'($urandom);
        // printing dominates so the cursor keeps reaching the right edge
        pick = $urandom_range(99);
        if (pick < 40)      item.command = CMD_PRINT;
        else if (pick < 50) item.command = CMD_ADDRESS;
        else if (pick < 95) item.command = 4'($urandom_range(CMD_RI, CMD_BS));
        else                item.command = 4'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        // most addresses land inside the screen or just past its edge
        if (item.command == CMD_ADDRESS && $urandom_range(4) != 0) begin
          item.row_code = 8'(int'(CODE_OFFSET) + $urandom_range(nrows));
          item.col_code = 8'(int'(CODE_OFFSET) + $urandom_range(cols));
        end
        send_command(item);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_default_screen();
    test_edge_modes();
    test_random_traffic(20, 79);
    test_random_traffic(79, 20);
    test_random_traffic(0, 0);
    wait_cursor_idle();
    // then wait on for any stray result item
    repeat (4) @(posedge clk);
    if (pending_cursor_results.size() != 0)
      report_mismatch($sformatf("%0d result items never arrived",
                                pending_cursor_results.size()));
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
